>>> hw/rtl/plcpn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package plcpn_pkg;

  localparam int MAX_SAMPLES_DEF = 16384;

  // multi-limb arithmetic for the exact power-law search
  localparam int LIMB_W = 16;
  localparam int NLIMB = 20;
  localparam int LIDX_W = $clog2(NLIMB);
  localparam int CNT_W = 5;
  localparam int RHS_MULS = 20;
  localparam int FS_MULS = 3;
  localparam int P_MULS = 19;
  localparam int DIV_STEPS = 31;

  localparam logic [14:0] FULL_SCALE = 15'd32767;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RHS_MUL,
    S_SRCH,
    S_P_MUL,
    S_CMP,
    S_LOAD,
    S_DR_RD,
    S_DR_DEC,
    S_DIV,
    S_DR_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic drop;
    logic rhs_step;
    logic p_init;
    logic p_step;
    logic cmp_step;
    logic load_wr;
    logic rd_issue;
    logic dec;
    logic div_init;
    logic div_step;
    logic emit;
    logic emit_empty;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty_drain;
    logic compress;
    logic rhs_done;
    logic srch_done;
    logic p_done;
    logic cmp_done;
    logic scale;
    logic div_done;
  } stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/power_law_compress_peak_normalize.sv
`timescale 1ns / 1ps
`default_nettype none
// Buffers signed 16-bit samples (op 0) and drains one processed sample per
// request (op 1); a command is taken when start is high and busy is low.
// Each drain gives one result on out_* marked by out_valid for a single
// cycle; the receiver cannot stall it. A scaled drain runs a bit-serial
// divider before the result goes out. A compressed load runs an exact
// 20th-power search on a 16-bit limb multiplier before the write.
module power_law_compress_peak_normalize #(
  parameter int MAX_SAMPLES = plcpn_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             op,
  input  wire logic signed [15:0]               in_sample,
  input  wire logic                             cfg_we,
  input  wire logic [plcpn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [plcpn_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                  out_valid,
  output logic signed [15:0]                    out_sample,
  output logic                                  out_last,
  output logic                                  empty_res,
  output logic                                  overflowed
);
  import plcpn_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  plcpn_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  plcpn_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_sample  (in_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_sample (out_sample),
    .out_last   (out_last),
    .empty_res  (empty_res),
    .overflowed (overflowed)
  );

endmodule
`default_nettype wire

>>> hw/rtl/plcpn_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module plcpn_ram #(
  parameter int W = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/plcpn_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module plcpn_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            op,
  input  wire plcpn_pkg::stat_t stat,
  output plcpn_pkg::cmd_t      cmd,
  output logic                 busy
);
  import plcpn_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (op == OP_LOAD) begin
            if (!stat.full) begin
              state_next = stat.compress ? S_RHS_MUL : S_LOAD;
            end
          end else if (!stat.empty_drain) begin
            state_next = S_DR_RD;
          end
        end
      end
      S_RHS_MUL: if (stat.rhs_done) state_next = S_SRCH;
      S_SRCH:    state_next = stat.srch_done ? S_LOAD : S_P_MUL;
      S_P_MUL:   if (stat.p_done) state_next = S_CMP;
      S_CMP:     if (stat.cmp_done) state_next = S_SRCH;
      S_LOAD:    state_next = S_IDLE;
      S_DR_RD:   state_next = S_DR_DEC;
      S_DR_DEC:  state_next = stat.scale ? S_DIV : S_DR_OUT;
      S_DIV:     if (stat.div_done) state_next = S_DR_OUT;
      S_DR_OUT:  state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          if (op == OP_LOAD) begin
            cmd.drop = stat.full;
          end else begin
            cmd.emit_empty = stat.empty_drain;
            cmd.rd_issue = !stat.empty_drain;
          end
        end
      end
      S_RHS_MUL: cmd.rhs_step = 1'b1;
      S_SRCH:    cmd.p_init = !stat.srch_done;
      S_P_MUL:   cmd.p_step = 1'b1;
      S_CMP:     cmd.cmp_step = 1'b1;
      S_LOAD:    cmd.load_wr = 1'b1;
      S_DR_RD:   cmd.dec = 1'b1;
      S_DR_DEC:  cmd.div_init = stat.scale;
      S_DIV:     cmd.div_step = 1'b1;
      S_DR_OUT:  cmd.emit = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/plcpn_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module plcpn_dp #(
  parameter int MAX_SAMPLES = plcpn_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic signed [15:0]               in_sample,
  input  wire logic                             cfg_we,
  input  wire logic [plcpn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [plcpn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire plcpn_pkg::cmd_t                  cmd,
  output plcpn_pkg::stat_t                      stat,
  output logic                                  out_valid,
  output logic signed [15:0]                    out_sample,
  output logic                                  out_last,
  output logic                                  empty_res,
  output logic                                  overflowed
);
  import plcpn_pkg::*;

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  function automatic logic [15:0] mag16(input logic [15:0] v);
    return v[15] ? 16'(17'h10000 - {1'b0, v}) : v;
  endfunction

  // configuration
  logic        compress_enable;
  logic        normalize_enable;
  logic [14:0] gain_limit;

  // buffer state
  logic [CW-1:0] sample_count;
  logic [CW-1:0] drain_index;
  logic [15:0]   peak;
  logic          drop_flag;

  // load path
  logic [15:0] sample_r;
  logic [15:0] mag_r;
  logic        cmp_en;
  logic [14:0] lo, hi, mid;
  logic [LIMB_W-1:0] rhs_limb [NLIMB];
  logic [LIMB_W-1:0] p_limb [NLIMB];
  logic [LIDX_W-1:0] limb_idx;
  logic [CNT_W-1:0]  mul_cnt;
  logic [LIMB_W-1:0] carry;

  // drain path
  logic [15:0] orig_rd, comp_rd;
  logic [15:0] orig_r;
  logic        neg_r;
  logic        scale_r;
  logic [30:0] prod_r;
  logic [30:0] dividend;
  logic [30:0] quot;
  logic [16:0] rem;
  logic [CNT_W-1:0] div_cnt;

  logic              limb_last;
  logic [15:0]       factor;
  logic [LIMB_W-1:0] src_limb;
  logic [31:0]       mprod;
  logic [14:0]       mid_next;
  logic              cmp_le;
  logic [15:0]       load_c, load_m;
  logic [15:0]       vmag;
  logic [30:0]       gain_prod;
  logic [16:0]       rem_sh;
  logic              qbit;
  logic [14:0]       q_clip;
  logic [15:0]       scaled;
  logic              is_last;

  assign limb_last = (limb_idx == LIDX_W'(NLIMB - 1));
  assign factor = cmd.p_step ? {1'b0, mid}
                : ((mul_cnt < CNT_W'(FS_MULS)) ? {1'b0, FULL_SCALE} : mag_r);
  assign src_limb = cmd.p_step ? p_limb[limb_idx] : rhs_limb[limb_idx];
  assign mprod = 32'(src_limb) * 32'(factor) + 32'(carry);
  assign mid_next = 15'((16'(lo) + 16'(hi) + 16'd1) >> 1);
  assign cmp_le = (p_limb[limb_idx] <= rhs_limb[limb_idx]);

  assign load_c = cmp_en ? (sample_r[15] ? 16'(17'h10000 - 17'(lo)) : {1'b0, lo}) : sample_r;
  assign load_m = cmp_en ? {1'b0, lo} : mag_r;

  assign vmag = mag16(comp_rd);
  assign gain_prod = 31'(gain_limit) * 31'(peak);

  assign rem_sh = {rem[15:0], dividend[30]};
  assign qbit = (rem_sh >= {1'b0, peak});
  assign q_clip = (quot > 31'(FULL_SCALE)) ? FULL_SCALE : quot[14:0];
  assign scaled = neg_r ? 16'(17'h10000 - 17'(q_clip)) : {1'b0, q_clip};
  assign is_last = ((CW + 1)'(drain_index) + (CW + 1)'(1) >= (CW + 1)'(sample_count));

  assign stat.full = (sample_count == CW'(MAX_SAMPLES));
  assign stat.empty_drain = (sample_count == '0) || (drain_index >= sample_count);
  assign stat.compress = compress_enable;
  assign stat.rhs_done = limb_last && (mul_cnt == CNT_W'(RHS_MULS - 1));
  assign stat.srch_done = (lo >= hi);
  assign stat.p_done = limb_last && (mul_cnt == CNT_W'(P_MULS - 1));
  assign stat.cmp_done = (p_limb[limb_idx] != rhs_limb[limb_idx]) || (limb_idx == '0);
  assign stat.scale = scale_r;
  assign stat.div_done = (div_cnt == CNT_W'(DIV_STEPS - 1));

  plcpn_ram #(.W(16), .DEPTH(MAX_SAMPLES)) u_orig_ram (
    .clk   (clk),
    .we    (cmd.load_wr),
    .waddr (sample_count[AW-1:0]),
    .wdata (sample_r),
    .re    (cmd.rd_issue),
    .raddr (drain_index[AW-1:0]),
    .rdata (orig_rd)
  );

  plcpn_ram #(.W(16), .DEPTH(MAX_SAMPLES)) u_comp_ram (
    .clk   (clk),
    .we    (cmd.load_wr),
    .waddr (sample_count[AW-1:0]),
    .wdata (load_c),
    .re    (cmd.rd_issue),
    .raddr (drain_index[AW-1:0]),
    .rdata (comp_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      compress_enable <= 1'b1;
      normalize_enable <= 1'b1;
      gain_limit <= 15'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COMPRESS:  compress_enable <= cfg_data[0];
        CFG_NORMALIZE: normalize_enable <= cfg_data[0];
        CFG_GAIN:      gain_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      drain_index <= '0;
      peak <= '0;
      drop_flag <= 1'b0;
    end else begin
      if (cmd.drop) begin
        drop_flag <= 1'b1;
      end
      if (cmd.load_wr) begin
        sample_count <= sample_count + CW'(1);
        if (load_m > peak) peak <= load_m;
      end
      if (cmd.emit) begin
        if (is_last) begin
          sample_count <= '0;
          drain_index <= '0;
          peak <= '0;
          drop_flag <= 1'b0;
        end else begin
          drain_index <= drain_index + CW'(1);
        end
      end
    end
  end

  // exact power-law search: largest y with y^20 <= 32767^3 * mag^17
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
      mag_r <= mag16(in_sample);
      cmp_en <= compress_enable;
      lo <= '0;
      hi <= FULL_SCALE;
      limb_idx <= '0;
      mul_cnt <= '0;
      carry <= '0;
      for (int i = 0; i < NLIMB; i++) begin
        rhs_limb[i] <= (i == 0) ? LIMB_W'(1) : '0;
      end
    end
    if (cmd.rhs_step) begin
      rhs_limb[limb_idx] <= mprod[LIMB_W-1:0];
      carry <= limb_last ? '0 : mprod[31:LIMB_W];
      limb_idx <= limb_last ? '0 : limb_idx + LIDX_W'(1);
      if (limb_last) mul_cnt <= mul_cnt + CNT_W'(1);
    end
    if (cmd.p_init) begin
      mid <= mid_next;
      for (int i = 0; i < NLIMB; i++) begin
        p_limb[i] <= (i == 0) ? {1'b0, mid_next} : '0;
      end
      limb_idx <= '0;
      mul_cnt <= '0;
      carry <= '0;
    end
    if (cmd.p_step) begin
      p_limb[limb_idx] <= mprod[LIMB_W-1:0];
      carry <= limb_last ? '0 : mprod[31:LIMB_W];
      if (stat.p_done) begin
        limb_idx <= LIDX_W'(NLIMB - 1);
      end else begin
        limb_idx <= limb_last ? '0 : limb_idx + LIDX_W'(1);
      end
      if (limb_last) mul_cnt <= mul_cnt + CNT_W'(1);
    end
    if (cmd.cmp_step) begin
      if (stat.cmp_done) begin
        if (cmp_le) lo <= mid;
        else hi <= mid - 15'd1;
      end else begin
        limb_idx <= limb_idx - LIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dec) begin
      orig_r <= orig_rd;
      neg_r <= comp_rd[15];
      prod_r <= 31'(FULL_SCALE) * 31'(vmag);
      scale_r <= normalize_enable && (peak != '0) && (gain_prod > 31'(FULL_SCALE));
    end
    if (cmd.div_init) begin
      dividend <= prod_r;
      rem <= '0;
      quot <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem <= qbit ? (rem_sh - {1'b0, peak}) : rem_sh;
      quot <= {quot[29:0], qbit};
      dividend <= {dividend[29:0], 1'b0};
      div_cnt <= div_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit || cmd.emit_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample <= scale_r ? scaled : orig_r;
      out_last <= is_last;
      empty_res <= 1'b0;
      overflowed <= drop_flag;
    end else if (cmd.emit_empty) begin
      out_sample <= '0;
      out_last <= 1'b0;
      empty_res <= 1'b1;
      overflowed <= drop_flag;
    end
  end

endmodule
`default_nettype wire

>>> sim/tb_power_law_compress_peak_normalize.sv
`timescale 1ns / 1ps
module tb_power_law_compress_peak_normalize;
  import plcpn_pkg::*;

  localparam int DEPTH = 16384;

  typedef struct packed {
    logic signed [15:0] smp;
    logic last;
    logic empty;
    logic ovf;
  } drain_res_t;

  typedef struct packed {
    logic op;
    logic [15:0] smp;
    logic typed;
    drain_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic op = OP_LOAD;
  logic signed [15:0] in_sample = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_COMPRESS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic busy, out_valid, out_last, empty_res, overflowed;
  logic signed [15:0] out_sample;

  power_law_compress_peak_normalize dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .in_sample(in_sample), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_sample(out_sample),
    .out_last(out_last), .empty_res(empty_res), .overflowed(overflowed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #500_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // shadow of the buffer and settings
  logic [15:0] orig_buf [DEPTH];
  logic [15:0] comp_buf [DEPTH];
  int buf_cnt, peak_mag, drain_pos;
  logic drop_seen;
  logic mdl_compress, mdl_normalize;
  logic [14:0] mdl_gain;

  drain_res_t pending_res[$];
  int errors, n_loads, n_drains, n_results, n_dropped;
  bit no_gap;

  function automatic int mag16(logic [15:0] v);
    return v[15] ? 32'h10000 - int'(v) : int'(v);
  endfunction

  // largest y with y^20 <= 32767^3 * m^17
  function automatic int pow_compress(int m);
    logic [319:0] rhs, p;
    int lo, hi, mid;
    if (m == 0) return 0;
    rhs = 320'd1;
    repeat (3) rhs = rhs * 320'd32767;
    repeat (17) rhs = rhs * 320'(m);
    lo = 0;
    hi = 32767;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      p = 320'd1;
      repeat (20) p = p * 320'(mid);
      if (p <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  task automatic apply_sample(input logic o, input logic [15:0] s,
                              output bit has_res, output drain_res_t r);
    int m, y, q;
    logic [15:0] c, v;
    has_res = 0;
    r = '0;
    if (o == OP_LOAD) begin
      n_loads++;
      if (buf_cnt >= DEPTH) begin
        drop_seen = 1'b1;
        n_dropped++;
        return;
      end
      m = mag16(s);
      c = s;
      if (mdl_compress) begin
        y = pow_compress(m);
        c = s[15] ? 16'(32'h10000 - y) : 16'(y);
        m = y;
      end
      orig_buf[buf_cnt] = s;
      comp_buf[buf_cnt] = c;
      if (m > peak_mag) peak_mag = m;
      buf_cnt++;
      return;
    end
    n_drains++;
    has_res = 1;
    r.ovf = drop_seen;
    if (buf_cnt == 0 || drain_pos >= buf_cnt) begin
      r.empty = 1'b1;
      return;
    end
    r.smp = orig_buf[drain_pos];
    if (mdl_normalize && peak_mag != 0 && int'(mdl_gain) * peak_mag > 32767) begin
      v = comp_buf[drain_pos];
      q = (32767 * mag16(v)) / peak_mag;
      if (q > 32767) q = 32767;
      r.smp = v[15] ? 16'(32'h10000 - q) : 16'(q);
    end
    r.last = (drain_pos + 1 >= buf_cnt);
    if (r.last) begin
      buf_cnt = 0;
      peak_mag = 0;
      drain_pos = 0;
      drop_seen = 1'b0;
    end else begin
      drain_pos++;
    end
  endtask

  task automatic send(input logic o, input logic [15:0] s,
                      input bit typed = 0, input drain_res_t texp = '0);
    int gap;
    bit has_res;
    drain_res_t r;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    op <= o;
    in_sample <= s;
    start <= 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    apply_sample(o, s, has_res, r);
    if (has_res) pending_res.push_back(typed ? texp : r);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    start <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_COMPRESS: mdl_compress = val[0];
      CFG_NORMALIZE: mdl_normalize = val[0];
      default: mdl_gain = 15'(val);
    endcase
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 4)) - 16'd2;
      3: return 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int items);
    int sent, k, i;
    sent = 0;
    while (sent < items) begin
      no_gap = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        send(logic'($urandom_range(0, 1)), rand_sample());
        sent++;
      end else begin
        k = $urandom_range(1, 8);
        for (i = 0; i < k; i++) send(OP_LOAD, rand_sample());
        for (i = 0; i < k; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            send(OP_LOAD, rand_sample());
            k++;
          end
          send(OP_DRAIN, 16'($urandom));
        end
        if ($urandom_range(0, 4) == 0) send(OP_DRAIN, 16'($urandom));
        sent += 2 * k;
      end
    end
    no_gap = 0;
  endtask

  always @(posedge clk) begin
    drain_res_t e;
    if (!rst && out_valid) begin
      n_results++;
      if (pending_res.size() == 0) begin
        errors++;
        $display("%0t: unexpected result sample=%0d last=%b empty=%b ovf=%b",
                 $time, out_sample, out_last, empty_res, overflowed);
      end else begin
        e = pending_res.pop_front();
        if (out_sample !== e.smp || out_last !== e.last ||
            empty_res !== e.empty || overflowed !== e.ovf) begin
          errors++;
          $display("%0t: mismatch exp sample=%0d last=%b empty=%b ovf=%b", $time,
                   e.smp, e.last, e.empty, e.ovf);
          $display("%0t:          got sample=%0d last=%b empty=%b ovf=%b", $time,
                   out_sample, out_last, empty_res, overflowed);
        end
      end
    end
  end

  // typed rows use reset settings: compress on, normalize on, gain 100
  stim_row_t directed [] = '{
    '{OP_DRAIN, 16'h0000, 1'b1, '{16'sd0, 1'b0, 1'b1, 1'b0}},
    '{OP_LOAD, 16'h7FFF, 1'b0, '0},
    '{OP_DRAIN, 16'h0000, 1'b1, '{16'sd32767, 1'b1, 1'b0, 1'b0}},
    '{OP_LOAD, 16'h8000, 1'b0, '0},
    '{OP_DRAIN, 16'hFFFF, 1'b1, '{-16'sd32767, 1'b1, 1'b0, 1'b0}},
    '{OP_LOAD, 16'h0000, 1'b0, '0},
    '{OP_DRAIN, 16'h0000, 1'b1, '{16'sd0, 1'b1, 1'b0, 1'b0}},
    '{OP_LOAD, 16'h0001, 1'b0, '0},
    '{OP_LOAD, 16'hFFFF, 1'b0, '0},
    '{OP_LOAD, 16'h3039, 1'b0, '0},
    '{OP_LOAD, 16'hB1E0, 1'b0, '0},
    '{OP_LOAD, 16'h5555, 1'b0, '0},
    '{OP_LOAD, 16'hAAAA, 1'b0, '0},
    '{OP_DRAIN, 16'h0000, 1'b0, '0},
    '{OP_DRAIN, 16'h0000, 1'b0, '0},
    '{OP_DRAIN, 16'h0000, 1'b0, '0},
    '{OP_DRAIN, 16'h0000, 1'b0, '0},
    '{OP_DRAIN, 16'h0000, 1'b0, '0},
    '{OP_DRAIN, 16'h0000, 1'b0, '0},
    '{OP_LOAD, 16'h0064, 1'b0, '0},
    '{OP_LOAD, 16'h0002, 1'b0, '0},
    '{OP_DRAIN, 16'h0000, 1'b0, '0},
    '{OP_LOAD, 16'hFF38, 1'b0, '0},
    '{OP_DRAIN, 16'h0000, 1'b0, '0},
    '{OP_DRAIN, 16'h0000, 1'b0, '0}
  };

  initial begin
    int w;
    buf_cnt = 0;
    peak_mag = 0;
    drain_pos = 0;
    drop_seen = 1'b0;
    mdl_compress = 1'b1;
    mdl_normalize = 1'b1;
    mdl_gain = 15'd100;
    errors = 0;
    n_loads = 0;
    n_drains = 0;
    n_results = 0;
    n_dropped = 0;
    no_gap = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send(directed[i].op, directed[i].smp, directed[i].typed,
                               directed[i].res);
    settle();

    write_cfg(CFG_COMPRESS, 0);
    random_phase(300);
    settle();
    write_cfg(CFG_GAIN, 1);
    random_phase(200);
    settle();
    write_cfg(CFG_GAIN, 32767);
    random_phase(300);
    settle();
    write_cfg(CFG_NORMALIZE, 0);
    random_phase(200);
    settle();
    write_cfg(CFG_COMPRESS, 1);
    random_phase(50);
    settle();
    write_cfg(CFG_NORMALIZE, 1);
    write_cfg(CFG_GAIN, 7);
    random_phase(60);
    settle();
    write_cfg(CFG_COMPRESS, 0);
    write_cfg(CFG_GAIN, 300);
    random_phase(250);

    @(negedge clk);
    start <= 1'b0;
    w = 0;
    while (pending_res.size() != 0 && w < 100000) begin
      @(negedge clk);
      w++;
    end
    w = 0;
    while (busy && w < 10000) begin
      @(negedge clk);
      w++;
    end
    repeat (50) @(negedge clk);
    if (pending_res.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_res.size());
    end
    $display("Covered %0d loads (%0d dropped when full) and %0d drains, %0d results",
             n_loads, n_dropped, n_drains, n_results);
    $display("across compression, normalization and gain settings incl. extremes.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
